// ----- hdl/ne_etp_pkg.sv -----
// Package for the NE entry table parser: codes, constants and the result type.
`timescale 1ns / 1ps

package ne_etp_pkg;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_SEGMENT = 3'd1;
  localparam logic [2:0] PH_ENTRY   = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;

  localparam logic [7:0] MARKER_LOW   = 8'hCD;
  localparam logic [7:0] MARKER_HIGH  = 8'h3F;
  localparam logic [7:0] SEG_MOVABLE  = 8'hFF;

  localparam logic [2:0] POS_FLAGS    = 3'd0;
  localparam logic [2:0] POS_MARK_LO  = 3'd1;
  localparam logic [2:0] POS_MARK_HI  = 3'd2;
  localparam logic [2:0] POS_SEGMENT  = 3'd3;
  localparam logic [2:0] POS_OFF_LOW  = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ordinal;
    logic [7:0]  entry_flags;
    logic [7:0]  segment;
    logic [15:0] offset;
    logic        movable;
    logic        last_of_run;
  } result_t;

endpackage

// ----- hdl/ne_entry_table_parser.sv -----
// Top level of the NE entry table parser: byte parse and result queue.
`timescale 1ns / 1ps

// Streaming parser for the entry table of a 16-bit NE executable. Bytes
// arrive one beat at a time on the in_ channel; in_tuser marks the first
// byte of a table (the parse restarts, ordinals back to 1) and in_tlast
// the last byte of the span. Each entry gives one result beat with its
// ordinal, flags, segment, offset and a movable mark; a zero count gives an
// end beat and a truncated table or a bad INT 3Fh marker an error beat, after
// which the consumer should discard that table's entries. The bundle state
// updates in the cycle a byte is accepted, and that byte's results go into
// a four-beat result queue. A byte that gives two results (an entry followed
// by a truncation error) pushes both beats together; in_tready drops only
// while fewer than two queue slots are free, so with out_tready held high
// the block sustains one byte per cycle.
module ne_entry_table_parser
  import ne_etp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] ordinal, [23:16] entry_flags,
                                  // [31:24] segment, [47:32] offset,
                                  // [48] movable, [55:49] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  // Parse state
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [7:0]  bseg_r, bseg_nxt;
  logic [15:0] ord_r, ord_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  hflags_r, hflags_nxt;
  logic [7:0]  hseg_r, hseg_nxt;
  logic [7:0]  hoff_r, hoff_nxt;
  logic        mok_r, mok_nxt;

  // Result queue
  result_t             queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;

  logic     in_acc, out_acc;
  logic     emit0, emit_trunc;
  result_t  pres, slot0, slot1;
  logic [1:0] n_push;

  // Effective state after a restart
  logic [2:0]  ph_e;
  logic [7:0]  rem_e, bseg_e, hf_e, hs_e, ho_e;
  logic [15:0] ord_e;
  logic [2:0]  pos_e;
  logic        mok_e;
  logic        movable;
  logic        entry_fin;
  logic [7:0]  rem_dec;

  assign in_tready = (count_r <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_acc   = out_tvalid && out_tready;

  always_comb begin
    // restart: take the byte against reset state
    ph_e   = in_tuser ? PH_COUNT : phase_r;
    rem_e  = in_tuser ? 8'd0 : remain_r;
    bseg_e = in_tuser ? 8'd0 : bseg_r;
    ord_e  = in_tuser ? 16'd1 : ord_r;
    pos_e  = in_tuser ? 3'd0 : pos_r;
    hf_e   = in_tuser ? 8'd0 : hflags_r;
    hs_e   = in_tuser ? 8'd0 : hseg_r;
    ho_e   = in_tuser ? 8'd0 : hoff_r;
    mok_e  = in_tuser ? 1'b1 : mok_r;

    phase_nxt  = ph_e;
    remain_nxt = rem_e;
    bseg_nxt   = bseg_e;
    ord_nxt    = ord_e;
    pos_nxt    = pos_e;
    hflags_nxt = hf_e;
    hseg_nxt   = hs_e;
    hoff_nxt   = ho_e;
    mok_nxt    = mok_e;

    movable   = (bseg_e == SEG_MOVABLE);
    entry_fin = 1'b0;
    rem_dec   = rem_e - 8'd1;
    emit0     = 1'b0;
    pres      = '0;

    case (ph_e)
      PH_COUNT: begin
        if (in_tdata == 8'd0) begin
          emit0     = 1'b1;
          pres.kind = KIND_END;
          phase_nxt = PH_DONE;
        end else begin
          remain_nxt = in_tdata;
          phase_nxt  = PH_SEGMENT;
        end
      end
      PH_SEGMENT: begin
        bseg_nxt = in_tdata;
        if (in_tdata == 8'd0) begin
          // skip bundle: advance ordinals, no entries
          ord_nxt    = ord_e + {8'd0, rem_e};
          remain_nxt = 8'd0;
          phase_nxt  = PH_COUNT;
        end else begin
          pos_nxt   = 3'd0;
          mok_nxt   = 1'b1;
          phase_nxt = PH_ENTRY;
        end
      end
      PH_ENTRY: begin
        pos_nxt = pos_e + 3'd1;
        if (pos_e == POS_FLAGS) begin
          hflags_nxt = in_tdata;
        end else if (!movable) begin
          if (pos_e == POS_MARK_LO) begin
            hoff_nxt = in_tdata;
          end else begin
            emit0            = 1'b1;
            pres.kind        = KIND_ENTRY;
            pres.ordinal     = ord_e;
            pres.entry_flags = hf_e;
            pres.segment     = bseg_e;
            pres.offset      = {in_tdata, ho_e};
            entry_fin        = 1'b1;
          end
        end else if (pos_e == POS_MARK_LO) begin
          if (in_tdata != MARKER_LOW) mok_nxt = 1'b0;
        end else if (pos_e == POS_MARK_HI) begin
          if (in_tdata != MARKER_HIGH) mok_nxt = 1'b0;
        end else if (pos_e == POS_SEGMENT) begin
          hseg_nxt = in_tdata;
        end else if (pos_e == POS_OFF_LOW) begin
          hoff_nxt = in_tdata;
        end else if (!mok_e) begin
          // bad INT 3Fh marker: stop the parse
          emit0     = 1'b1;
          pres.kind = KIND_ERROR;
          pos_nxt   = 3'd0;
          mok_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          emit0            = 1'b1;
          pres.kind        = KIND_ENTRY;
          pres.ordinal     = ord_e;
          pres.entry_flags = hf_e;
          pres.segment     = hs_e;
          pres.offset      = {in_tdata, ho_e};
          pres.movable     = 1'b1;
          entry_fin        = 1'b1;
        end
        if (entry_fin) begin
          ord_nxt    = ord_e + 16'd1;
          pos_nxt    = 3'd0;
          mok_nxt    = 1'b1;
          remain_nxt = rem_dec;
          phase_nxt  = (rem_dec == 8'd0) ? PH_COUNT : PH_ENTRY;
        end
      end
      default: begin
      end
    endcase

    // truncation: span ends while the table is still open
    emit_trunc = in_tlast && (phase_nxt != PH_DONE);
    if (emit_trunc) phase_nxt = PH_DONE;

    slot0 = '0;
    slot1 = '0;
    slot1.kind = KIND_ERROR;
    slot1.last_of_run = 1'b1;
    if (emit0) begin
      slot0 = pres;
      slot0.last_of_run = !emit_trunc;
    end else begin
      slot0 = slot1;
    end
    n_push = {1'b0, emit0} + {1'b0, emit_trunc};
    if (!in_acc) n_push = 2'd0;

    count_nxt = count_r + {{(QPTR_W-1){1'b0}}, n_push}
              - {{QPTR_W{1'b0}}, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COUNT;
      remain_r <= 8'd0;
      bseg_r   <= 8'd0;
      ord_r    <= 16'd1;
      pos_r    <= 3'd0;
      hflags_r <= 8'd0;
      hseg_r   <= 8'd0;
      hoff_r   <= 8'd0;
      mok_r    <= 1'b1;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        phase_r  <= phase_nxt;
        remain_r <= remain_nxt;
        bseg_r   <= bseg_nxt;
        ord_r    <= ord_nxt;
        pos_r    <= pos_nxt;
        hflags_r <= hflags_nxt;
        hseg_r   <= hseg_nxt;
        hoff_r   <= hoff_nxt;
        mok_r    <= mok_nxt;
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      end
      if (out_acc) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // Queue storage: push up to two beats per accepted byte
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue_r[wr_ptr_r] <= slot0;
    if (n_push == 2'd2) queue_r[wr_ptr_r + QPTR_W'(1)] <= slot1;
  end

  result_t head;
  assign head      = queue_r[rd_ptr_r];
  assign out_tdata = {7'd0, head.movable, head.offset, head.segment,
                      head.entry_flags, head.ordinal};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

endmodule
